[rtl/assert_macros.svh]
// assertion macros shared by the semaphore rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define CSFW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define CSFW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/csfw_pkg.sv]
// package: types and constants of the counting semaphore with fifo wait queue
`default_nettype none

package csfw_pkg;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned TASK_ID_BITS = 8;
  localparam int unsigned COUNT_BITS   = 16;
  localparam int unsigned CFG_BITS     = 16;
  localparam int unsigned STATUS_BITS  = 3;

  localparam logic [CFG_BITS-1:0] INIT_COUNT_RESET = 16'd1;

  typedef enum logic {
    CMD_DOWN = 1'b0,
    CMD_UP   = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_RAISED    = 3'd2,
    ST_WOKEN     = 3'd3,
    ST_FULL      = 3'd4,
    ST_SATURATED = 3'd5
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic cfg_load;
  } dp_cmd_t;

endpackage

`default_nettype wire

[rtl/counting_semaphore_fifo_waiters_unit.sv]
// top level: counting semaphore with a fifo wait queue of task ids
// a request captured in IDLE is executed in EXEC once the output register is free
// a new request is taken only after the last one has executed, as the registered read of
//   the wait queue memory at the head pointer comes ahead of the grant/queue/wake decision
// a finished result may wait in the output register while the next request is taken
// reset: count loads 1, wait queue empty; queue memory is not cleared (no clearing pass)
`default_nettype none

module counting_semaphore_fifo_waiters_unit #(
  parameter int unsigned QUEUE_DEPTH  = csfw_pkg::QUEUE_DEPTH,
  parameter int unsigned TASK_ID_BITS = csfw_pkg::TASK_ID_BITS,
  parameter int unsigned COUNT_BITS   = csfw_pkg::COUNT_BITS,
  localparam int unsigned OCC_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          command_i,
  input  wire logic [TASK_ID_BITS-1:0]       task_id_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [csfw_pkg::STATUS_BITS-1:0]   status_o,
  output logic [TASK_ID_BITS-1:0]            woken_task_o,
  output logic [COUNT_BITS-1:0]              count_now_o,
  output logic [OCC_BITS-1:0]                waiters_now_o,
  // initial count register write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [csfw_pkg::CFG_BITS-1:0] cfg_data_i
);

  // command bundle: capture a request, execute it, reload on a config transfer
  csfw_pkg::dp_cmd_t cmd;

  // controller owns the handshakes and the output valid
  csfw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  // datapath holds count, pointers, wait queue and the result register
  csfw_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .command_i     (command_i),
    .task_id_i     (task_id_i),
    .cfg_data_i    (cfg_data_i),
    .status_o      (status_o),
    .woken_task_o  (woken_task_o),
    .count_now_o   (count_now_o),
    .waiters_now_o (waiters_now_o)
  );

endmodule

`default_nettype wire

[rtl/csfw_ctrl.sv]
// controller: handshake state machine of the semaphore
`default_nettype none

`include "assert_macros.svh"

module csfw_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  output csfw_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = (state_q == IDLE);
  // config has priority over a request in the same cycle
  assign in_stall_o  = (state_q != IDLE) || cfg_valid_i;
  assign out_valid_o = out_valid_q;

  assign cmd_o.capture  = in_valid_i && !in_stall_o;
  assign cmd_o.execute  = (state_q == EXEC) && out_free;
  assign cmd_o.cfg_load = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (cmd_o.capture) begin
            state_q <= EXEC;
          end
        end
        EXEC: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  `CSFW_ASSERT(a_result_from_exec, $rose(out_valid_q) |-> $past(state_q == EXEC), "result without execute")
  `CSFW_ASSERT_ALWAYS(a_no_cfg_with_req, !(cmd_o.capture && cmd_o.cfg_load), "config and request together")

endmodule

`default_nettype wire

[rtl/csfw_dp.sv]
// datapath: resource count, wait queue memory and result registers
`default_nettype none

`include "assert_macros.svh"

module csfw_dp #(
  parameter int unsigned QUEUE_DEPTH  = csfw_pkg::QUEUE_DEPTH,
  parameter int unsigned TASK_ID_BITS = csfw_pkg::TASK_ID_BITS,
  parameter int unsigned COUNT_BITS   = csfw_pkg::COUNT_BITS,
  localparam int unsigned PTR_BITS    = $clog2(QUEUE_DEPTH),
  localparam int unsigned OCC_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire csfw_pkg::dp_cmd_t                cmd_i,
  input  wire logic                             command_i,
  input  wire logic [TASK_ID_BITS-1:0]          task_id_i,
  input  wire logic [csfw_pkg::CFG_BITS-1:0]    cfg_data_i,
  output logic [csfw_pkg::STATUS_BITS-1:0]      status_o,
  output logic [TASK_ID_BITS-1:0]               woken_task_o,
  output logic [COUNT_BITS-1:0]                 count_now_o,
  output logic [OCC_BITS-1:0]                   waiters_now_o
);

  // captured request
  csfw_pkg::cmd_e          cmd_q;
  logic [TASK_ID_BITS-1:0] tid_q;

  // semaphore state
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [PTR_BITS-1:0]   head_q, head_d;
  logic [PTR_BITS-1:0]   tail_q, tail_d;
  logic [OCC_BITS-1:0]   occ_q, occ_d;

  // wait queue
  logic [TASK_ID_BITS-1:0] queue_mem_q [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0] rd_data_q;
  logic                    push;

  // result
  csfw_pkg::status_e       status_q, status_d;
  logic [TASK_ID_BITS-1:0] woken_q, woken_d;
  logic [COUNT_BITS-1:0]   count_now_q;
  logic [OCC_BITS-1:0]     waiters_q;

  logic occ_full;

  assign occ_full = (occ_q == OCC_BITS'(QUEUE_DEPTH));

  always_comb begin
    status_d = csfw_pkg::ST_GRANTED;
    woken_d  = '0;
    count_d  = count_q;
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    push     = 1'b0;
    if (cmd_q == csfw_pkg::CMD_DOWN) begin
      if (count_q != '0) begin
        count_d  = count_q - COUNT_BITS'(1);
        status_d = csfw_pkg::ST_GRANTED;
      end else if (!occ_full) begin
        push     = 1'b1;
        tail_d   = (tail_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_BITS'(1);
        occ_d    = occ_q + OCC_BITS'(1);
        status_d = csfw_pkg::ST_QUEUED;
      end else begin
        status_d = csfw_pkg::ST_FULL;
      end
    end else begin
      if (occ_q != '0) begin
        woken_d  = rd_data_q;
        head_d   = (head_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_BITS'(1);
        occ_d    = occ_q - OCC_BITS'(1);
        status_d = csfw_pkg::ST_WOKEN;
      end else if (count_q == '1) begin
        status_d = csfw_pkg::ST_SATURATED;
      end else begin
        count_d  = count_q + COUNT_BITS'(1);
        status_d = csfw_pkg::ST_RAISED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_BITS'(csfw_pkg::INIT_COUNT_RESET);
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
    end else if (cmd_i.cfg_load) begin
      count_q <= COUNT_BITS'(cfg_data_i);
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
    end
  end

  // head is stable from capture to execute, so the read is ready in time
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && push) begin
      queue_mem_q[tail_q] <= tid_q;
    end
    rd_data_q <= queue_mem_q[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= csfw_pkg::cmd_e'(command_i);
      tid_q <= task_id_i;
    end
    if (cmd_i.execute) begin
      status_q    <= status_d;
      woken_q     <= woken_d;
      count_now_q <= count_d;
      waiters_q   <= occ_d;
    end
  end

  assign status_o      = status_q;
  assign woken_task_o  = woken_q;
  assign count_now_o   = count_now_q;
  assign waiters_now_o = waiters_q;

  `CSFW_ASSERT(a_occ_bound, occ_q <= OCC_BITS'(QUEUE_DEPTH), "wait queue occupancy over depth")
  `CSFW_ASSERT(a_wait_only_at_zero, (occ_q != '0) |-> (count_q == '0), "waiters while resources free")

endmodule

`default_nettype wire

[verif/tb_counting_semaphore_fifo_waiters_unit.sv]
// testbench for the counting semaphore unit: directed and random requests against a predictor
module tb_counting_semaphore_fifo_waiters_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import csfw_pkg::*;

  localparam int unsigned OCC_BITS        = $clog2(QUEUE_DEPTH + 1);
  // no transfer on any channel for this many cycles ends the run
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  // cycles let pass after the last result before the block counts as idle
  localparam int unsigned SETTLE_CYCLES   = 3;
  // long receiver hold-off used to back the block up into its input
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // one expected result, laid out like the output ports
  typedef struct packed {
    status_e                 status;
    logic [TASK_ID_BITS-1:0] woken_task;
    logic [COUNT_BITS-1:0]   count_now;
    logic [OCC_BITS-1:0]     waiters_now;
  } sem_result_t;

  // clock and reset, reset held low from time zero
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request channel
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    command_i  = 1'b0;
  logic [TASK_ID_BITS-1:0] task_id_i  = '0;

  // result channel
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [STATUS_BITS-1:0]  status_o;
  logic [TASK_ID_BITS-1:0] woken_task_o;
  logic [COUNT_BITS-1:0]   count_now_o;
  logic [OCC_BITS-1:0]     waiters_now_o;

  // initial count register write channel
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_BITS-1:0]     cfg_data_i  = '0;

  // results predicted for accepted requests, oldest first
  sem_result_t expected_results[$];
  int unsigned mismatch_count = 0;

  // per-item idle draws of each side, 0 gives back-to-back transfers
  int unsigned tx_idle_max = 19;
  int unsigned rx_idle_max = 19;
  // set by a test to make the result side hold off once for that many cycles
  int unsigned sink_hold_cycles = 0;

  // predictor state: register copy, resource count and the wait queue ring
  logic [CFG_BITS-1:0]     model_init_count;
  logic [COUNT_BITS-1:0]   model_count;
  logic [TASK_ID_BITS-1:0] model_waiters [QUEUE_DEPTH];
  int unsigned             model_head;
  int unsigned             model_tail;
  int unsigned             model_occ;

  counting_semaphore_fifo_waiters_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .task_id_i    (task_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .woken_task_o (woken_task_o),
    .count_now_o  (count_now_o),
    .waiters_now_o(waiters_now_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // 8 ns clock period
  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // ring pointer advance with wrap at the queue depth
  function automatic int unsigned next_slot(int unsigned ptr);
    return (ptr + 1 >= QUEUE_DEPTH) ? 0 : ptr + 1;
  endfunction

  // reload the count from the register and empty the wait queue
  function automatic void model_reinit();
    model_count = model_init_count[COUNT_BITS-1:0];
    model_head  = 0;
    model_tail  = 0;
    model_occ   = 0;
  endfunction

  // apply one request to the predictor state and return the result it causes
  function automatic sem_result_t semaphore_predict(cmd_e cmd, logic [TASK_ID_BITS-1:0] tid);
    sem_result_t res;
    res.woken_task = '0;
    if (cmd == CMD_DOWN) begin
      if (model_count != '0) begin
        // a resource is free, take it
        model_count = model_count - 1'b1;
        res.status  = ST_GRANTED;
      end else if (model_occ < QUEUE_DEPTH) begin
        // no resource, the task joins the tail of the wait queue
        model_waiters[model_tail] = tid;
        model_tail = next_slot(model_tail);
        model_occ  = model_occ + 1;
        res.status = ST_QUEUED;
      end else begin
        // queue full, nothing changes
        res.status = ST_FULL;
      end
    end else begin
      if (model_occ > 0) begin
        // hand the released resource straight to the oldest waiter
        res.woken_task = model_waiters[model_head];
        model_head = next_slot(model_head);
        model_occ  = model_occ - 1;
        res.status = ST_WOKEN;
      end else if (model_count == COUNT_MAX) begin
        // count stays pinned at its maximum
        res.status = ST_SATURATED;
      end else begin
        model_count = model_count + 1'b1;
        res.status  = ST_RAISED;
      end
    end
    res.count_now   = model_count;
    res.waiters_now = OCC_BITS'(model_occ);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // offer one request after a random gap, predict its result once transferred
  // valid is left high after the transfer so a back-to-back request needs no dip
  task automatic send_request(cmd_e cmd, logic [TASK_ID_BITS-1:0] tid);
    int unsigned gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      // idle cycles carry junk payload with valid low
      in_valid_i <= 1'b0;
      command_i  <= 1'($urandom_range(0, 1));
      task_id_i  <= TASK_ID_BITS'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    task_id_i  <= tid;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(semaphore_predict(cmd, tid));
  endtask

  // stop offering requests and wait until every predicted result has come
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write the initial count register while the block is idle
  task automatic load_initial_count(logic [CFG_BITS-1:0] value);
    wait_results_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    // the write re-initializes the semaphore
    model_init_count = value;
    model_reinit();
  endtask

  // a run of random requests, down_pct percent of them down requests
  task automatic run_random_phase(int unsigned items, int unsigned down_pct);
    cmd_e cmd;
    repeat (items) begin
      if ($urandom_range(0, 99) < down_pct) cmd = CMD_DOWN;
      else cmd = CMD_UP;
      send_request(cmd, TASK_ID_BITS'($urandom_range(0, (1 << TASK_ID_BITS) - 1)));
    end
  endtask

  // result side: stall for a random number of cycles, then take one result
  // a requested hold-off replaces the random draw once
  initial begin : result_sink
    int unsigned wait_cycles;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (sink_hold_cycles != 0) begin
        wait_cycles      = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, rx_idle_max);
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // every result transfer is compared with the oldest prediction
  always @(posedge clk_i) begin : result_check
    sem_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d woken %0d count %0d waiters %0d",
                 $time, status_o, woken_task_o, count_now_o, waiters_now_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("woken_task", want.woken_task, woken_task_o);
        check_field("count_now", want.count_now, count_now_o);
        check_field("waiters_now", want.waiters_now, waiters_now_o);
      end
    end
  end

  // watchdog: any transfer restarts the quiet count
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still expected", $time,
               expected_results.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset count of one: grant id 0, queue the all-ones id and 8'hA5, wake them in order, raise
  task automatic test_reset_default();
    send_request(CMD_DOWN, '0);
    send_request(CMD_DOWN, '1);
    send_request(CMD_DOWN, TASK_ID_BITS'(8'hA5));
    send_request(CMD_UP, '0);
    send_request(CMD_UP, '1);
    send_request(CMD_UP, '0);
  endtask

  // zero count: fill the wait queue, one more down is rejected, then wake some
  task automatic test_full_queue();
    logic [TASK_ID_BITS-1:0] tid;
    load_initial_count('0);
    for (int i = 0; i <= QUEUE_DEPTH; i++) begin
      if (i == 0) tid = '0;
      else if (i == 1) tid = '1;
      else tid = TASK_ID_BITS'($urandom);
      send_request(CMD_DOWN, tid);
    end
    send_request(CMD_UP, TASK_ID_BITS'($urandom));
    send_request(CMD_UP, TASK_ID_BITS'($urandom));
  endtask

  // maximum count, loaded over a non-empty queue: the write must clear the waiters
  task automatic test_saturation();
    load_initial_count('1);
    send_request(CMD_UP, TASK_ID_BITS'($urandom));
    send_request(CMD_DOWN, TASK_ID_BITS'($urandom));
    send_request(CMD_UP, TASK_ID_BITS'($urandom));
    send_request(CMD_UP, TASK_ID_BITS'($urandom));
  endtask

  // receiver holds off for a long stretch while requests keep coming back to back
  task automatic test_output_hold_off();
    load_initial_count('0);
    tx_idle_max      = 0;
    sink_hold_cycles = HOLD_OFF_CYCLES;
    run_random_phase(40, 50);
    tx_idle_max      = 19;
  endtask

  // sender pauses until every result is back, then goes on
  task automatic test_pause_until_drained();
    load_initial_count(CFG_BITS'($urandom_range(0, 2)));
    run_random_phase(12, 60);
    wait_results_drained();
    run_random_phase(12, 40);
  endtask

  // random requests over several counts and idle patterns
  task automatic test_random_mix();
    // balanced traffic around an empty count, idling on both sides
    tx_idle_max = 19;
    rx_idle_max = 19;
    load_initial_count('0);
    run_random_phase(120, 50);

    // small count, no idling at all
    tx_idle_max = 0;
    rx_idle_max = 0;
    load_initial_count(CFG_BITS'($urandom_range(1, 4)));
    run_random_phase(120, 55);

    // near the maximum, mostly up requests to hit saturation
    tx_idle_max = 0;
    rx_idle_max = 19;
    load_initial_count(CFG_BITS'($urandom_range(16'hFFFD, 16'hFFFF)));
    run_random_phase(60, 30);

    // down heavy from zero so the queue fills and rejects often
    tx_idle_max = 19;
    rx_idle_max = 0;
    load_initial_count('0);
    run_random_phase(120, 65);

    // any count
    tx_idle_max = 19;
    rx_idle_max = 19;
    load_initial_count(CFG_BITS'($urandom_range(0, 16'hFFFF)));
    run_random_phase(40, 50);

    // back to the reset value
    load_initial_count(INIT_COUNT_RESET);
    run_random_phase(20, 50);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : test_sequence
    model_init_count = INIT_COUNT_RESET;
    model_reinit();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_default();
    test_full_queue();
    test_saturation();
    test_output_hold_off();
    test_pause_until_drained();
    test_random_mix();

    // all requests sent, wait for the last results
    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/csfw_pkg.sv
rtl/csfw_ctrl.sv
rtl/csfw_dp.sv
rtl/counting_semaphore_fifo_waiters_unit.sv
verif/tb_counting_semaphore_fifo_waiters_unit.sv
